### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)
`define ASSERT_SAME(lbl, ante, cons)
`endif
`endif

### hdl/tdps_pkg.sv
// ----------------------------------------------------------------------------
// Tail-drop scheduler package
// Sizes, arithmetic unit operations, request/response types and ring step.
// ----------------------------------------------------------------------------
package tdps_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int OCC_W     = $clog2(BUF_DEPTH + 1);
    localparam int CFG_W     = 7;
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;

    typedef enum logic [1:0]
    {
        ALU_LE,
        ALU_MAX,
        ALU_ADD_SAT
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t             op;
        logic [TIME_W-1:0]   a;
        logic [TIME_W-1:0]   b;
    } alu_req_t;

    typedef struct packed
    {
        logic [TIME_W-1:0]   value;
        logic                flag;
    } alu_rsp_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        begin
            if (p == PTR_W'(BUF_DEPTH - 1))
            begin
                r = '0;
            end
            else
            begin
                r = p + PTR_W'(1);
            end
            return r;
        end
    endfunction

endpackage

### hdl/tdps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tdps_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/tdps_alu.sv
// ----------------------------------------------------------------------------
// Shared time unit
// Compare, maximum and saturating add over 32-bit tick values.
// ----------------------------------------------------------------------------
module tdps_alu
    import tdps_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [TIME_W:0] sum;

    always_comb
    begin
        sum       = {1'b0, req.a} + {1'b0, req.b};
        rsp.flag  = (req.a <= req.b);
        rsp.value = req.a;
        unique case (req.op)
            ALU_LE:
            begin
                rsp.value = req.a;
            end
            ALU_MAX:
            begin
                rsp.value = (req.a > req.b) ? req.a : req.b;
            end
            ALU_ADD_SAT:
            begin
                rsp.value = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
            end
            default:
            begin
                rsp.value = req.a;
            end
        endcase
    end

endmodule

### hdl/tail_drop_packet_scheduler_top.sv
// ----------------------------------------------------------------------------
// Tail-drop packet scheduler
// Schedules packets on one server behind a bounded buffer; drops when full.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one packet request: arrival_time and duration.
//   m_tdata/m_tuser return one result per request: start_time and dropped.
//   cfg_we/cfg_wdata write buffer_size (capped at 64); the user must write it
//   only while the block idles, which the block itself does not enforce.
// Sequencing:
//   A request passes IDLE and CHECK when dropped, and IDLE, CHECK, START and
//   FINISH when accepted; each buffered packet retired on its arrival adds a
//   LOOK and CHECK pass. m_tvalid rises from the output register once CHECK
//   (dropped) or FINISH (accepted) ends with a free slot. Retirement reads
//   the finish-time RAM one entry at a time; every compare, max and add goes
//   through the one shared time unit. s_tready is high only in S_IDLE.
// Reset:
//   The buffer empties, last finish time clears, buffer_size returns to 64.
//   No RAM clearing pass is needed; only written entries are read.
// Stall:
//   A finished result sits in the output register; the block takes the next
//   request meanwhile and holds its own result until m_tready frees the slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tail_drop_packet_scheduler_top
    import tdps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // arrival_time[31:0], duration[47:32]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // start_time[31:0]
    output logic [0:0]          m_tuser,   // dropped[0]
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_START,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   arr_reg, arr_next;
    logic [DUR_W-1:0]    dur_reg, dur_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [CFG_W-1:0]    size_reg;
    logic                out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]   out_time_reg, out_time_next;
    logic                out_drop_reg, out_drop_next;

    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;
    logic [TIME_W-1:0]   ram_rdata;
    logic                ram_we;
    logic [OCC_W-1:0]    cap;
    logic                slot_free;

    tdps_ram
    #(
        .WIDTH(TIME_W),
        .DEPTH(BUF_DEPTH)
    )
    u_fifo_ram
    (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(alu_rsp.value),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    tdps_alu u_alu
    (
        .req(alu_req),
        .rsp(alu_rsp)
    );

    assign cap       = (size_reg > CFG_W'(BUF_DEPTH)) ? OCC_W'(BUF_DEPTH) : OCC_W'(size_reg);
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_time_reg;
    assign m_tuser   = out_drop_reg;
    assign ram_we    = (state_reg == S_FINISH) && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        arr_next       = arr_reg;
        dur_next       = dur_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_time_next  = out_time_reg;
        out_drop_next  = out_drop_reg;
        alu_req.op     = ALU_LE;
        alu_req.a      = ram_rdata;
        alu_req.b      = arr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    arr_next   = s_tdata[TIME_W-1:0];
                    dur_next   = s_tdata[TIME_W+DUR_W-1:TIME_W];
                    state_next = S_CHECK;
                end
            end
            S_LOOK:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if ((occ_reg != '0) && alu_rsp.flag)
                begin
                    head_next  = ring_next(head_reg);
                    occ_next   = occ_reg - OCC_W'(1);
                    state_next = S_LOOK;
                end
                else if (occ_reg >= cap)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_time_next  = '0;
                        out_drop_next  = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                alu_req.op = ALU_MAX;
                alu_req.a  = arr_reg;
                alu_req.b  = last_reg;
                start_next = alu_rsp.value;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                alu_req.op = ALU_ADD_SAT;
                alu_req.a  = start_reg;
                alu_req.b  = TIME_W'(dur_reg);
                if (slot_free)
                begin
                    tail_next      = ring_next(tail_reg);
                    occ_next       = occ_reg + OCC_W'(1);
                    last_next      = alu_rsp.value;
                    out_valid_next = 1'b1;
                    out_time_next  = start_reg;
                    out_drop_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            arr_reg       <= '0;
            dur_reg       <= '0;
            start_reg     <= '0;
            last_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            size_reg      <= CFG_W'(64);
            out_valid_reg <= 1'b0;
            out_time_reg  <= '0;
            out_drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            arr_reg       <= arr_next;
            dur_reg       <= dur_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            out_time_reg  <= out_time_next;
            out_drop_reg  <= out_drop_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    `ASSERT_ALWAYS(a_occ_bound, occ_reg <= OCC_W'(BUF_DEPTH))
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `ASSERT_SAME(a_drop_zero_start, m_tvalid && m_tuser[0], m_tdata == '0)
    `ASSERT_SAME(a_write_has_room, ram_we, occ_reg < cap)

endmodule

### dv/tail_drop_packet_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// Tail-drop packet scheduler testbench
// Drives packet requests: directed head rows, randomised phases (each with
// its own buffer size, load and idling), then tail rows. Results are compared
// with checked rows' values or an in-bench finish-time buffer scheduler.
// ----------------------------------------------------------------------------
module tail_drop_packet_scheduler_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tdps_pkg::*;

    localparam int HEAD_ROWS   = 18;
    localparam int PLAN_ROWS   = 25;
    localparam int PHASES      = 10;
    localparam int QUIET_LIMIT = 4000;

    typedef enum logic
    {
        ROW_PACKET,
        ROW_CONFIG
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t           kind;
        logic [TIME_W-1:0]   arrival;
        logic [DUR_W-1:0]    duration;
        logic [CFG_W-1:0]    size;
        logic                check;
        logic [TIME_W-1:0]   want_start;
        logic                want_dropped;
    } plan_row_t;

    typedef struct packed
    {
        logic [TIME_W-1:0]   start_time;
        logic                dropped;
    } sched_result_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata   = '0;   // arrival_time[31:0], duration[47:32]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;          // start_time[31:0]
    logic [0:0]          m_tuser;          // dropped[0]
    logic                cfg_we    = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    logic [TIME_W-1:0]   finish_times[$];
    logic [TIME_W-1:0]   last_finish_time = '0;
    logic [CFG_W-1:0]    buffer_size_now  = CFG_W'(64);
    sched_result_t       pending_results[$];
    sched_result_t       oldest_result;

    int                  failures   = 0;
    int                  quiet      = 0;
    int                  stall_left = 0;
    bit                  idle_on    = 1'b1;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_PACKET, 32'd0,          16'd0,      7'd0,   1'b1, 32'd0,          1'b0},
        '{ROW_PACKET, 32'd0,          16'd0,      7'd0,   1'b1, 32'd0,          1'b0},
        '{ROW_PACKET, 32'd100,        16'hFFFF,   7'd0,   1'b1, 32'd100,        1'b0},
        '{ROW_PACKET, 32'd100,        16'd1000,   7'd0,   1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'd100,        16'd1000,   7'd0,   1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'd200,        16'd1,      7'd0,   1'b0, 32'd0,          1'b0},
        '{ROW_CONFIG, 32'd0,          16'd0,      7'd2,   1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'd300,        16'd5,      7'd0,   1'b1, 32'd0,          1'b1},
        '{ROW_PACKET, 32'd65635,      16'd5,      7'd0,   1'b1, 32'd0,          1'b1},
        '{ROW_PACKET, 32'd66635,      16'd5,      7'd0,   1'b1, 32'd0,          1'b1},
        '{ROW_PACKET, 32'd67635,      16'd7,      7'd0,   1'b0, 32'd0,          1'b0},
        '{ROW_CONFIG, 32'd0,          16'd0,      7'd0,   1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'd70000,      16'd3,      7'd0,   1'b1, 32'd0,          1'b1},
        '{ROW_PACKET, 32'd70000,      16'hFFFF,   7'd0,   1'b1, 32'd0,          1'b1},
        '{ROW_CONFIG, 32'd0,          16'd0,      7'd127, 1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'd70010,      16'd20,     7'd0,   1'b1, 32'd70010,      1'b0},
        '{ROW_PACKET, 32'd50,         16'd10,     7'd0,   1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'd70040,      16'h8000,   7'd0,   1'b0, 32'd0,          1'b0},
        '{ROW_CONFIG, 32'd0,          16'd0,      7'd64,  1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'hFFFF_FFF0,  16'hFFFF,   7'd0,   1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'hFFFF_FFFF,  16'hFFFF,   7'd0,   1'b1, 32'hFFFF_FFFF,  1'b0},
        '{ROW_PACKET, 32'hFFFF_FFFF,  16'd0,      7'd0,   1'b1, 32'hFFFF_FFFF,  1'b0},
        '{ROW_CONFIG, 32'd0,          16'd0,      7'd1,   1'b0, 32'd0,          1'b0},
        '{ROW_PACKET, 32'hFFFF_FFFF,  16'd1,      7'd0,   1'b1, 32'hFFFF_FFFF,  1'b0},
        '{ROW_PACKET, 32'd7,          16'd2,      7'd0,   1'b1, 32'd0,          1'b1}
    };

    logic [CFG_W-1:0] phase_sizes [PHASES] = '{
        7'd1, 7'd127, 7'd2, 7'd64, 7'd0, 7'd8, 7'd65, 7'd3, 7'd33, 7'd64
    };

    tail_drop_packet_scheduler_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic sched_result_t schedule_packet(input logic [TIME_W-1:0] arrival,
                                                      input logic [DUR_W-1:0] duration);
        sched_result_t       res;
        int                  cap;
        logic [TIME_W-1:0]   start;
        logic [TIME_W:0]     finish;
        begin
            cap = (int'(buffer_size_now) > BUF_DEPTH) ? BUF_DEPTH : int'(buffer_size_now);
            while (finish_times.size() > 0 && finish_times[0] <= arrival)
            begin
                void'(finish_times.pop_front());
            end
            if (finish_times.size() >= cap)
            begin
                res.start_time = '0;
                res.dropped    = 1'b1;
            end
            else
            begin
                start  = (arrival > last_finish_time) ? arrival : last_finish_time;
                finish = {1'b0, start} + {17'd0, duration};
                if (finish[TIME_W])
                begin
                    finish = {1'b0, {TIME_W{1'b1}}};
                end
                finish_times.push_back(finish[TIME_W-1:0]);
                last_finish_time = finish[TIME_W-1:0];
                res.start_time   = start;
                res.dropped      = 1'b0;
            end
            return res;
        end
    endfunction

    task automatic send_packet(input logic [TIME_W-1:0] arrival, input logic [DUR_W-1:0] duration,
                               input logic check, input logic [TIME_W-1:0] want_start,
                               input logic want_dropped);
        sched_result_t predicted;
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {duration, arrival};
            do @(posedge clk); while (s_tready !== 1'b1);
            predicted = schedule_packet(arrival, duration);
            if (check)
            begin
                predicted.start_time = want_start;
                predicted.dropped    = want_dropped;
            end
            pending_results.push_back(predicted);
        end
    endtask

    // drain every outstanding request, then write the size while idle
    task automatic write_buffer_size(input logic [CFG_W-1:0] size);
        begin
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clk);
            repeat (4) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= size;
            @(posedge clk);
            cfg_we          <= 1'b0;
            buffer_size_now  = size;
        end
    endtask

    task automatic run_row(input plan_row_t row);
        begin
            if (row.kind == ROW_CONFIG)
            begin
                write_buffer_size(row.size);
            end
            else
            begin
                send_packet(row.arrival, row.duration, row.check, row.want_start,
                            row.want_dropped);
            end
        end
    endtask

    initial
    begin
        logic [TIME_W-1:0]   now_arrival;
        logic [TIME_W-1:0]   arrival;
        logic [DUR_W-1:0]    duration;
        int                  gap_max;
        int                  items;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < HEAD_ROWS; i++)
        begin
            run_row(plan[i]);
        end

        phase_sizes[7] = CFG_W'($urandom_range(1, 126));
        for (int p = 0; p < PHASES; p++)
        begin
            write_buffer_size(phase_sizes[p]);
            idle_on     = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            now_arrival = 32'h0010_0000 + p * 32'h1800_0000 + $urandom_range(0, 32'h0FFF_FFFF);
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 'h40;
                2:       gap_max = 'h400;
                default: gap_max = 'h4000;
            endcase
            items = (phase_sizes[p] == 0) ? 20 : 118;
            for (int n = 0; n < items; n++)
            begin
                case ($urandom_range(0, 7))
                    0:       duration = '0;
                    1:       duration = DUR_W'($urandom_range(0, 16'hFFFF));
                    default: duration = DUR_W'($urandom_range(0, 'h7FF));
                endcase
                if ($urandom_range(0, 19) == 0)
                begin
                    arrival = now_arrival - $urandom_range(1, 'h1000);
                end
                else
                begin
                    now_arrival = now_arrival + $urandom_range(0, gap_max);
                    arrival     = now_arrival;
                end
                send_packet(arrival, duration, 1'b0, '0, 1'b0);
            end
        end

        idle_on = 1'b0;
        for (int i = HEAD_ROWS; i < PLAN_ROWS; i++)
        begin
            run_row(plan[i]);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: start_time %0d dropped %0d", m_tdata, m_tuser[0]);
                failures++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_tdata !== oldest_result.start_time)
                begin
                    $error("start_time: expected %0d, got %0d", oldest_result.start_time,
                           m_tdata);
                    failures++;
                end
                if (m_tuser[0] !== oldest_result.dropped)
                begin
                    $error("dropped: expected %0d, got %0d", oldest_result.dropped, m_tuser[0]);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
        end
        if (quiet == QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

### sim.f
+incdir+hdl
hdl/tdps_pkg.sv
hdl/tdps_ram.sv
hdl/tdps_alu.sv
hdl/tail_drop_packet_scheduler_top.sv
dv/tail_drop_packet_scheduler_top_tb.sv
